### hw/rtl/bsub_pkg.sv
`default_nettype none
package bsub_pkg;

	localparam int MAX_SIZE_DEF = 32;

	localparam int DATA_W    = 32;
	localparam int ROW_W     = 5;
	localparam int SIZE_W    = 6;
	localparam int CFG_ADDR_W = 3;
	localparam int ACC_W     = 64;

	// register map
	localparam logic REG_SIZE_IN_USE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

	// command codes
	localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
	localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
	localparam logic [1:0] CMD_SOLVE       = 2'd2;

	// numerator clamp: +/-(2^47 - 1)
	localparam logic signed [ACC_W-1:0] NUM_CLAMP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam int NUM_MAG_W  = 47;
	localparam int DIVIDEND_W = NUM_MAG_W + 16;
	localparam int DIV_STEPS  = DIVIDEND_W;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/bsub_if.sv
`default_nettype none
interface bsub_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         cmd;
	logic [bsub_pkg::ROW_W-1:0]         row;
	logic [bsub_pkg::ROW_W-1:0]         col;
	logic signed [bsub_pkg::DATA_W-1:0] value;

	modport source(output valid, cmd, row, col, value, input ready);
	modport sink(input valid, cmd, row, col, value, output ready);
endinterface

interface bsub_sol_if;
	logic                               valid;
	logic                               ready;
	logic [bsub_pkg::ROW_W-1:0]         index;
	logic signed [bsub_pkg::DATA_W-1:0] solution_value;
	logic                               zero_pivot;
	logic                               last;

	modport source(output valid, index, solution_value, zero_pivot, last, input ready);
	modport sink(input valid, index, solution_value, zero_pivot, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/bsub_cfg.sv
`default_nettype none
module bsub_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [bsub_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	output logic [bsub_pkg::SIZE_W-1:0]            size_in_use
);

	logic [bsub_pkg::SIZE_W-1:0] size_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == bsub_pkg::REG_SIZE_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= bsub_pkg::SIZE_RESET;
		end else if (wr_en) begin
			size_q <= pwdata[bsub_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bsub_pkg::REG_SIZE_IN_USE) begin
			prdata = {{(32-bsub_pkg::SIZE_W){1'b0}}, size_q};
		end
	end

	assign size_in_use = size_q;

endmodule
`default_nettype wire

### hw/rtl/bsub_store.sv
`default_nettype none
module bsub_store #(
	parameter int MAX_SIZE = bsub_pkg::MAX_SIZE_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  m_we,
	input  wire logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]  m_waddr,
	input  wire logic [bsub_pkg::DATA_W-1:0]           m_wdata,
	input  wire logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]  m_raddr,
	output logic [bsub_pkg::DATA_W-1:0]                m_rdata,
	input  wire logic                                  r_we,
	input  wire logic [$clog2(MAX_SIZE)-1:0]           r_waddr,
	input  wire logic [bsub_pkg::DATA_W-1:0]           r_wdata,
	input  wire logic [$clog2(MAX_SIZE)-1:0]           r_raddr,
	output logic [bsub_pkg::DATA_W-1:0]                r_rdata,
	input  wire logic                                  s_we,
	input  wire logic [$clog2(MAX_SIZE)-1:0]           s_waddr,
	input  wire logic [bsub_pkg::DATA_W-1:0]           s_wdata,
	input  wire logic [$clog2(MAX_SIZE)-1:0]           s_raddr,
	output logic [bsub_pkg::DATA_W-1:0]                s_rdata
);

	logic [bsub_pkg::DATA_W-1:0] mat_mem [MAX_SIZE*MAX_SIZE];
	logic [bsub_pkg::DATA_W-1:0] rhs_mem [MAX_SIZE];
	logic [bsub_pkg::DATA_W-1:0] sol_mem [MAX_SIZE];

	always_ff @(posedge clk) begin
		if (m_we) begin
			mat_mem[m_waddr] <= m_wdata;
		end
		m_rdata <= mat_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			rhs_mem[r_waddr] <= r_wdata;
		end
		r_rdata <= rhs_mem[r_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sol_mem[s_waddr] <= s_wdata;
		end
		s_rdata <= sol_mem[s_raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/bsub_div.sv
`default_nettype none
module bsub_div (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic signed [bsub_pkg::ACC_W-1:0]         num,
	input  wire logic signed [bsub_pkg::DATA_W-1:0]        den,
	output logic                                           done,
	output logic signed [bsub_pkg::DATA_W-1:0]             quot
);

	localparam int DW = bsub_pkg::DIVIDEND_W;
	localparam int CW = $clog2(bsub_pkg::DIV_STEPS);

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic [DW-1:0]                 dq_q;
	logic [31:0]                   rem_q;
	logic [31:0]                   dm_q;
	logic                          neg_q;

	logic signed [bsub_pkg::ACC_W-1:0] num_c;
	logic [bsub_pkg::ACC_W-1:0]        num_mag;
	logic [31:0]                       den_mag;
	logic [32:0]                       r2;
	logic                              ge;

	always_comb begin
		num_c = num;
		if (num > bsub_pkg::NUM_CLAMP) begin
			num_c = bsub_pkg::NUM_CLAMP;
		end else if (num < -bsub_pkg::NUM_CLAMP) begin
			num_c = -bsub_pkg::NUM_CLAMP;
		end
		num_mag = num_c[bsub_pkg::ACC_W-1] ? 64'(-num_c) : 64'(num_c);
		den_mag = den[31] ? (~den + 32'd1) : den;
		r2      = {rem_q, dq_q[DW-1]};
		ge      = r2 >= {1'b0, dm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(bsub_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {num_mag[bsub_pkg::NUM_MAG_W-1:0], 16'd0};
			rem_q <= '0;
			dm_q  <= den_mag;
			neg_q <= num_c[bsub_pkg::ACC_W-1] ^ den[31];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, dm_q}) : r2[31:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	// saturate the magnitude quotient to Q16.16
	always_comb begin
		if (neg_q) begin
			if (dq_q > DW'(64'h8000_0000)) begin
				quot = bsub_pkg::Q_MIN;
			end else begin
				quot = -$signed(dq_q[31:0]);
			end
		end else if (dq_q > DW'(64'h7FFF_FFFF)) begin
			quot = bsub_pkg::Q_MAX;
		end else begin
			quot = $signed(dq_q[31:0]);
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

### hw/rtl/upper_triangular_back_substitution_top.sv
`default_nettype none
// Load requests (matrix or rhs entry) are taken one per cycle and written in that cycle.
// Solve: row i of n issues (n-i) reads, then drains the pipe and runs the divider (63 steps and
// a done pulse, skipped on a zero diagonal), then emits, which waits while the output register
// is full. No request is taken until the solve has ended.
// Reset (arst_n low, asynchronous) clears control, sets size_in_use to 32; stores keep contents.
module upper_triangular_back_substitution_top #(
	parameter int MAX_SIZE = bsub_pkg::MAX_SIZE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	bsub_req_if.sink                             req,
	bsub_sol_if.source                           sol,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bsub_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	localparam int IW = $clog2(MAX_SIZE);
	localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);
	localparam int DW = bsub_pkg::DATA_W;

	bsub_pkg::state_t state_q;

	logic [bsub_pkg::SIZE_W-1:0] size_in_use;

	// store ports
	logic          m_we, r_we, s_we;
	logic [AW-1:0] m_waddr, m_raddr;
	logic [IW-1:0] r_waddr, s_waddr;
	logic [DW-1:0] m_rdata, r_rdata, s_rdata;

	// sequencer
	logic [IW-1:0] i_q, k_q, nm1_q, nm1;
	logic          accept, row_ok, col_ok, issue, first, slot_free, emit;

	// multiply-accumulate pipe
	logic                           v_s1, first_s1, v_s2;
	logic signed [2*DW-1:0]         prod_s2;
	logic signed [bsub_pkg::ACC_W-1:0] acc_q;
	logic signed [DW-1:0]           diag_q;

	// result of the row
	logic signed [DW-1:0] res_q;
	logic                 zp_q;

	// divider
	logic                 div_start, div_done;
	logic signed [DW-1:0] div_quot;

	// output register
	logic                 out_v_q;
	logic [bsub_pkg::ROW_W-1:0] out_idx_q;
	logic signed [DW-1:0] out_val_q;
	logic                 out_zp_q, out_last_q;

	bsub_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.size_in_use (size_in_use)
	);

	// Clamp the size: zero acts as one, anything past the array acts as the array.
	always_comb begin
		int n_int;
		n_int = int'(size_in_use);
		if (n_int < 1) begin
			n_int = 1;
		end
		if (n_int > MAX_SIZE) begin
			n_int = MAX_SIZE;
		end
		nm1 = IW'(n_int - 1);
	end

	// Take requests only while no solve is in progress.
	assign req.ready = (state_q == bsub_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign row_ok    = 32'(req.row) < MAX_SIZE;
	assign col_ok    = 32'(req.col) < MAX_SIZE;

	assign m_we    = accept && (req.cmd == bsub_pkg::CMD_LOAD_MATRIX) && row_ok && col_ok;
	assign m_waddr = AW'(int'(IW'(req.row)) * MAX_SIZE + int'(IW'(req.col)));
	assign r_we    = accept && (req.cmd == bsub_pkg::CMD_LOAD_RHS) && row_ok;
	assign r_waddr = IW'(req.row);

	// Read the diagonal and rhs on the first issue of a row, then one
	// off-diagonal entry with its solution per cycle.
	assign issue   = (state_q == bsub_pkg::ST_ISSUE);
	assign first   = (k_q == i_q);
	assign m_raddr = AW'(int'(i_q) * MAX_SIZE + int'(k_q));

	// Write the solution back as it leaves for the output register.
	assign slot_free = !out_v_q || sol.ready;
	assign emit      = (state_q == bsub_pkg::ST_EMIT) && slot_free;
	assign s_we      = emit;
	assign s_waddr   = i_q;

	bsub_store #(
		.MAX_SIZE (MAX_SIZE)
	) u_store (
		.clk     (clk),
		.m_we    (m_we),
		.m_waddr (m_waddr),
		.m_wdata (req.value),
		.m_raddr (m_raddr),
		.m_rdata (m_rdata),
		.r_we    (r_we),
		.r_waddr (r_waddr),
		.r_wdata (req.value),
		.r_raddr (i_q),
		.r_rdata (r_rdata),
		.s_we    (s_we),
		.s_waddr (s_waddr),
		.s_wdata (res_q),
		.s_raddr (k_q),
		.s_rdata (s_rdata)
	);

	// Start the divide once the pipe has drained and the pivot is usable.
	assign div_start = (state_q == bsub_pkg::ST_DRAIN) && !v_s1 && !v_s2 && (diag_q != '0);

	bsub_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (diag_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer: walk rows from the last one up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsub_pkg::ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			nm1_q   <= '0;
		end else begin
			case (state_q)
				bsub_pkg::ST_IDLE: begin
					if (accept && (req.cmd == bsub_pkg::CMD_SOLVE)) begin
						nm1_q   <= nm1;
						i_q     <= nm1;
						k_q     <= nm1;
						state_q <= bsub_pkg::ST_ISSUE;
					end
				end
				bsub_pkg::ST_ISSUE: begin
					if (k_q == nm1_q) begin
						state_q <= bsub_pkg::ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				bsub_pkg::ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= (diag_q == '0) ? bsub_pkg::ST_EMIT : bsub_pkg::ST_DIV;
					end
				end
				bsub_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= bsub_pkg::ST_EMIT;
					end
				end
				bsub_pkg::ST_EMIT: begin
					if (slot_free) begin
						if (i_q == '0) begin
							state_q <= bsub_pkg::ST_IDLE;
						end else begin
							i_q     <= i_q - 1'b1;
							k_q     <= i_q - 1'b1;
							state_q <= bsub_pkg::ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= bsub_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Pipe valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= first;
			v_s2     <= v_s1 && !first_s1;
		end
	end

	// Multiply, then round half up to Q16.16 and subtract.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (first_s1) begin
				diag_q <= $signed(m_rdata);
				acc_q  <= bsub_pkg::ACC_W'($signed(r_rdata));
			end else begin
				prod_s2 <= $signed(m_rdata) * $signed(s_rdata);
			end
		end
		if (v_s2) begin
			acc_q <= acc_q - ((prod_s2 + 64'sd32768) >>> 16);
		end
	end

	// Row result: a zero pivot forces 0 and the flag.
	always_ff @(posedge clk) begin
		if ((state_q == bsub_pkg::ST_DRAIN) && !v_s1 && !v_s2 && (diag_q == '0)) begin
			res_q <= '0;
			zp_q  <= 1'b1;
		end else if ((state_q == bsub_pkg::ST_DIV) && div_done) begin
			res_q <= div_quot;
			zp_q  <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (sol.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q  <= bsub_pkg::ROW_W'(i_q);
			out_val_q  <= res_q;
			out_zp_q   <= zp_q;
			out_last_q <= (i_q == '0);
		end
	end

	assign sol.valid          = out_v_q;
	assign sol.index          = out_idx_q;
	assign sol.solution_value = out_val_q;
	assign sol.zero_pivot     = out_zp_q;
	assign sol.last           = out_last_q;

	// Never divide by a zero pivot.
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> (diag_q != '0))
		else $error("divider started with zero pivot");

	// Drop no accumulation: the pipe is empty when the divide starts.
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> (!v_s1 && !v_s2))
		else $error("divider started before pipe drained");

	// A handed-over result is visible on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) emit |=> out_v_q)
		else $error("emitted result not presented");

	// The final element of a run is always row 0.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_last_q) |-> (out_idx_q == '0))
		else $error("last flag on a row other than 0");

endmodule
`default_nettype wire

### tb/upper_triangular_back_substitution_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
// Back substitution solver testbench.
// Requests load matrix and rhs entries, then a solve emits one solution per row,
// bottom row first. A mirror of the stores inside the bench computes every solution
// in Q16.16, and each solution the block hands out is checked against the oldest
// one still owed. A short directed table goes first, then phases of well-formed
// systems with random content and some noise between the loads.
module upper_triangular_back_substitution_top_test;

	localparam int DW = bsub_pkg::DATA_W;
	localparam int RW = bsub_pkg::ROW_W;
	localparam int SW = bsub_pkg::SIZE_W;
	localparam int PW = bsub_pkg::CFG_ADDR_W;
	localparam int N_MAX = bsub_pkg::MAX_SIZE_DEF;
	localparam int ITEMS_TARGET = 460;
	localparam int TAIL_START = 380;
	// per result: longest row walk, drain, divide and emit, plus the longest stall
	localparam int WORST_RESULT_CYCLES = 128;
	localparam int CYCLE_LIMIT = ITEMS_TARGET * N_MAX * WORST_RESULT_CYCLES * 4;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint NUM_LIMIT = (64'sd1 <<< 47) - 1;

	typedef struct packed {
		logic [RW-1:0]        index;
		logic signed [DW-1:0] value;
		logic                 zero_pivot;
		logic                 last;
	} solution_t;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [RW-1:0] row;
		logic [RW-1:0] col;
		logic [DW-1:0] value;
		logic [1:0]    typed_n;
		solution_t     typed0;
		solution_t     typed1;
	} directed_row_t;

	localparam solution_t NO_SOL = '0;

	// Directed table, run with size_in_use = 2. Typed results cover the zero pivot,
	// both saturation limits and plain divisions that can be read off by eye.
	localparam int N_DIRECTED = 22;
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_UNUSED,                5'd31, 5'd31, 32'hFFFF_FFFF, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd0,  5'd0,  32'h0001_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd0,  5'd1,  32'h0000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd1,  5'd1,  32'h0000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_RHS,    5'd0,  5'd31, 32'h0003_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_RHS,    5'd1,  5'd0,  32'h7FFF_FFFF, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd0,  5'd0,  32'h0000_0000, 2'd2,
			'{5'd1, 32'h0000_0000, 1'b1, 1'b0}, '{5'd0, 32'h0003_0000, 1'b0, 1'b1}},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd1,  5'd1,  32'h0000_0001, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd31, 5'd31, 32'hFFFF_FFFF, 2'd2,
			'{5'd1, 32'h7FFF_FFFF, 1'b0, 1'b0}, '{5'd0, 32'h0003_0000, 1'b0, 1'b1}},
		'{bsub_pkg::CMD_LOAD_RHS,    5'd1,  5'd0,  32'h8000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd0,  5'd0,  32'h0000_0000, 2'd2,
			'{5'd1, 32'h8000_0000, 1'b0, 1'b0}, '{5'd0, 32'h0003_0000, 1'b0, 1'b1}},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd0,  5'd1,  32'h8000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd0,  5'd0,  32'hFFFF_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd0,  5'd0,  32'h0000_0000, 2'd1,
			'{5'd1, 32'h8000_0000, 1'b0, 1'b0}, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd1,  5'd1,  32'hFFFF_FFFF, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_RHS,    5'd1,  5'd0,  32'h7FFF_FFFF, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd0,  5'd1,  32'h7FFF_FFFF, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd0,  5'd0,  32'h0000_0000, 2'd1,
			'{5'd1, 32'h8000_0000, 1'b0, 1'b0}, NO_SOL},
		'{bsub_pkg::CMD_LOAD_RHS,    5'd1,  5'd0,  32'h0000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_LOAD_MATRIX, 5'd1,  5'd1,  32'h8000_0000, 2'd0, NO_SOL, NO_SOL},
		'{bsub_pkg::CMD_SOLVE,       5'd0,  5'd0,  32'h0000_0000, 2'd2,
			'{5'd1, 32'h0000_0000, 1'b0, 1'b0}, '{5'd0, 32'hFFFD_0000, 1'b0, 1'b1}},
		'{CMD_UNUSED,                5'd0,  5'd0,  32'h0000_0000, 2'd0, NO_SOL, NO_SOL}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bsub_req_if req_ch();
	bsub_sol_if sol_ch();

	upper_triangular_back_substitution_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.sol(sol_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mirror of the block: stores, register and the solutions still owed
	logic signed [DW-1:0] mat_mirror [N_MAX][N_MAX];
	logic signed [DW-1:0] rhs_mirror [N_MAX];
	logic signed [DW-1:0] sol_mirror [N_MAX];
	logic [SW-1:0] size_reg = bsub_pkg::SIZE_RESET;
	solution_t owed_solutions [$];

	int mismatches = 0;
	int cycles = 0;
	int requests_sent = 0;
	int solves_sent = 0;
	int solutions_seen = 0;
	int gap_pct = 0;   // chance of a sender gap after each request
	int stall_pct = 0; // chance of a receiver stall burst per cycle
	int stall_left = 0;

	function automatic longint q16_mul(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return (p + 64'sd32768) >>> 16; // round half up
	endfunction

	function automatic logic signed [DW-1:0] q16_div(longint num,
			logic signed [DW-1:0] den);
		bit neg;
		bit [63:0] nm, dm, q;
		if (num > NUM_LIMIT) num = NUM_LIMIT;
		if (num < -NUM_LIMIT) num = -NUM_LIMIT;
		neg = num < 0;
		nm = neg ? 64'(-num) : 64'(num);
		if (den < 0) begin
			neg = !neg;
			dm = 64'(-longint'(den));
		end else begin
			dm = 64'(longint'(den));
		end
		q = (nm << 16) / dm;
		if (neg) begin
			if (q > 64'h8000_0000) return bsub_pkg::Q_MIN;
			return DW'(-longint'(q));
		end
		if (q > 64'h7FFF_FFFF) return bsub_pkg::Q_MAX;
		return DW'(q);
	endfunction

	// work out every solution of a solve, bottom row first, and queue them
	function automatic void solve_backwards();
		int n;
		longint acc;
		solution_t s;
		n = (size_reg == 0) ? 1 : (size_reg > N_MAX) ? N_MAX : int'(size_reg);
		for (int i = n - 1; i >= 0; i--) begin
			acc = longint'(rhs_mirror[i]);
			for (int k = i + 1; k < n; k++)
				acc -= q16_mul(mat_mirror[i][k], sol_mirror[k]);
			s.index = RW'(i);
			s.last = (i == 0);
			if (mat_mirror[i][i] == 0) begin
				s.value = '0;
				s.zero_pivot = 1'b1;
			end else begin
				s.value = q16_div(acc, mat_mirror[i][i]);
				s.zero_pivot = 1'b0;
			end
			sol_mirror[i] = s.value;
			owed_solutions.push_back(s);
		end
	endfunction

	function automatic void apply_request(logic [1:0] c, logic [RW-1:0] r,
			logic [RW-1:0] k, logic signed [DW-1:0] v);
		case (c)
			bsub_pkg::CMD_LOAD_MATRIX: mat_mirror[r][k] = v;
			bsub_pkg::CMD_LOAD_RHS: rhs_mirror[r] = v;
			bsub_pkg::CMD_SOLVE: begin
				solve_backwards();
				solves_sent++;
			end
			default: ;
		endcase
	endfunction

	// Present one request, hold it until taken, then perhaps leave a gap.
	// Ready is looked at on the falling edge, where it is settled.
	task automatic send_request(input logic [1:0] c, input logic [RW-1:0] r,
			input logic [RW-1:0] k, input logic [DW-1:0] v);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.row <= r;
		req_ch.col <= k;
		req_ch.value <= v;
		forever begin
			@(negedge clk);
			if (req_ch.ready === 1'b1) break;
		end
		@(posedge clk);
		apply_request(c, r, k, v);
		requests_sent++;
		if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
			gap = $urandom_range(14, 1);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_quiet();
		req_ch.valid <= 1'b0;
	endtask

	// drop valid and wait until every owed solution is in, then let the block settle
	task automatic wait_drained();
		hold_quiet();
		while (owed_solutions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SW-1:0] sz);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PW'(bsub_pkg::REG_SIZE_IN_USE) << 2;
		pwdata <= 32'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_reg = sz;
	endtask

	function automatic logic [DW-1:0] pick_entry();
		case ($urandom_range(7, 0))
			0: return $urandom();
			1: return '0;
			2: return $urandom_range(1, 0) ? bsub_pkg::Q_MAX : bsub_pkg::Q_MIN;
			default: return DW'($urandom_range(32'h4_0000, 0)) - 32'h2_0000;
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_diagonal();
		logic [DW-1:0] mag;
		case ($urandom_range(9, 0))
			0: return '0;
			1: return $urandom();
			2: mag = DW'($urandom_range(16, 1));
			default: mag = DW'($urandom_range(32'h3_0000, 32'h8000));
		endcase
		return $urandom_range(1, 0) ? -mag : mag;
	endfunction

	// Noise: an unused command, or a load below the diagonal, which a solve never reads.
	task automatic send_noise();
		logic [RW-1:0] r;
		r = RW'($urandom_range(N_MAX - 1, 1));
		if ($urandom_range(1, 0))
			send_request(CMD_UNUSED, RW'($urandom()), RW'($urandom()), $urandom());
		else
			send_request(bsub_pkg::CMD_LOAD_MATRIX, r, RW'($urandom_range(int'(r) - 1, 0)),
				pick_entry());
	endtask

	// load every entry a solve of size n reads, with noise sprinkled between
	task automatic load_system(input int n);
		for (int i = n - 1; i >= 0; i--) begin
			if ($urandom_range(9, 0) == 0) send_noise();
			send_request(bsub_pkg::CMD_LOAD_RHS, RW'(i), RW'($urandom()), pick_entry());
			for (int k = i; k < n; k++) begin
				if ($urandom_range(11, 0) == 0) send_noise();
				send_request(bsub_pkg::CMD_LOAD_MATRIX, RW'(i), RW'(k),
					(k == i) ? pick_diagonal() : pick_entry());
			end
		end
	endtask

	// one to three solves, some with a few entries rewritten in between
	task automatic run_solves(input int n);
		int reps, edits, r, k;
		reps = $urandom_range(3, 1);
		for (int s = 0; s < reps; s++) begin
			if (s > 0 && $urandom_range(1, 0)) begin
				edits = $urandom_range(3, 1);
				for (int e = 0; e < edits; e++) begin
					r = $urandom_range(n - 1, 0);
					k = $urandom_range(n - 1, r);
					if ($urandom_range(2, 0) == 0)
						send_request(bsub_pkg::CMD_LOAD_RHS, RW'(r), 5'd0, pick_entry());
					else
						send_request(bsub_pkg::CMD_LOAD_MATRIX, RW'(r), RW'(k),
							(k == r) ? pick_diagonal() : pick_entry());
				end
			end
			send_request(bsub_pkg::CMD_SOLVE, RW'($urandom()), RW'($urandom()), $urandom());
			// let the sender wait out the whole solve now and then
			if ($urandom_range(3, 0) == 0) wait_drained();
		end
	endtask

	function automatic void pick_idling();
		case ($urandom_range(3, 0))
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 10; stall_pct = 5; end
			2: begin gap_pct = 40; stall_pct = 20; end
			default: begin gap_pct = 5; stall_pct = 30; end
		endcase
	endfunction

	// receiver: ready held low in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sol_ch.ready <= 1'b0;
		end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
			stall_left <= $urandom_range(13, 0);
			sol_ch.ready <= 1'b0;
		end else begin
			sol_ch.ready <= 1'b1;
		end
	end

	// Check each solution taken: look on the falling edge, the rising edge that follows
	// takes it.
	always @(negedge clk) begin
		solution_t got, want;
		if (arst_n && sol_ch.valid === 1'b1 && sol_ch.ready === 1'b1) begin
			got = '{sol_ch.index, sol_ch.solution_value, sol_ch.zero_pivot, sol_ch.last};
			solutions_seen++;
			if (owed_solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected solution: index %0d value %h zp %b last %b",
						got.index, got.value, got.zero_pivot, got.last);
			end else begin
				want = owed_solutions.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("solution mismatch: expected index %0d value %h zp %b last %b",
							want.index, want.value, want.zero_pivot, want.last);
						$display("                   got      index %0d value %h zp %b last %b",
							got.index, got.value, got.zero_pivot, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("upper_triangular_back_substitution_top_test: FAIL");
			$finish;
		end
	end

	initial begin
		int owed_before;
		int n;
		req_ch.valid = 1'b0;
		req_ch.cmd = bsub_pkg::CMD_LOAD_MATRIX;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.value = '0;
		sol_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at size 2, no idling
		write_size(SW'(2));
		foreach (DIRECTED[d]) begin
			owed_before = owed_solutions.size();
			send_request(DIRECTED[d].cmd, DIRECTED[d].row, DIRECTED[d].col,
				DIRECTED[d].value);
			// typed results replace the mirror's own for the bottom rows
			if (DIRECTED[d].typed_n > 0) owed_solutions[owed_before] = DIRECTED[d].typed0;
			if (DIRECTED[d].typed_n > 1) owed_solutions[owed_before + 1] = DIRECTED[d].typed1;
		end

		// size extremes: 1, then 0 acting as 1
		pick_idling();
		write_size(SW'(1));
		load_system(1);
		run_solves(1);
		write_size(SW'(0));
		run_solves(1);

		// random systems; the tail of the run goes without idling
		while (requests_sent < ITEMS_TARGET) begin
			if (requests_sent > TAIL_START) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				pick_idling();
			end
			case ($urandom_range(9, 0))
				0: n = 1;
				1, 2: n = $urandom_range(12, 7);
				default: n = $urandom_range(6, 2);
			endcase
			write_size(SW'(n));
			load_system(n);
			run_solves(n);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests and %0d solves, %0d solutions checked,",
			requests_sent, solves_sent, solutions_seen);
		$display("sizes 0, 1 and 2 plus random systems of up to 12 rows, %0d mismatches",
			mismatches);
		if (mismatches == 0 && owed_solutions.size() == 0)
			$display("upper_triangular_back_substitution_top_test: PASS");
		else
			$display("upper_triangular_back_substitution_top_test: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/bsub_pkg.sv
hw/rtl/bsub_if.sv
hw/rtl/bsub_cfg.sv
hw/rtl/bsub_store.sv
hw/rtl/bsub_div.sv
hw/rtl/upper_triangular_back_substitution_top.sv
tb/upper_triangular_back_substitution_top_test.sv
